// File: rtl/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the rgb to hsl converter
// Holds hue sector codes, divider lane layout and the pipeline word.
// ----------------------------------------------------------------------------
package rhc_pkg;

   // number of restoring divide steps, one quotient bit each
   localparam int DIV_STEPS = 16;

   // hue scale: one sector is 60 degrees in 1/64 degree units
   localparam logic [14:0] HUE_SECTOR     = 15'd3840;
   localparam logic [14:0] HUE_FULL       = 15'd23040;
   localparam logic [14:0] HUE_GREEN_BASE = 15'd7680;
   localparam logic [14:0] HUE_BLUE_BASE  = 15'd15360;

   // lightness sum limits
   localparam logic [8:0] CHAN_TOP   = 9'd255;
   localparam logic [8:0] LIGHT_FULL = 9'd510;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SECT_RED   = 2'd0,
      SECT_GREEN = 2'd1,
      SECT_BLUE  = 2'd2
   } sector_type;

   // one restoring divider lane: partial remainder, dividend bits shifting
   // out at the top while quotient bits shift in at the bottom
   typedef struct packed {
      logic [7:0]  rem;
      logic [15:0] work;
      logic [7:0]  divisor;
   } lane_type;

   // pipeline word carried from stage to stage
   typedef struct packed {
      sector_type sector;
      logic       neg;
      logic       grey;
      logic       sat_zero;
      logic [8:0] light_sum;
      lane_type   hue_lane;
      lane_type   sat_lane;
   } pipe_type;

endpackage

// File: rtl/rgb_to_hsl_convert.sv
// Pipeline: one setup stage, 16 divide stages at one quotient bit each and one
// output stage lie between an accepted req transfer and rsp_valid.
// Throughput: one pixel per clock while req_stall is low; a stall on rsp only
// holds stages that are full, so empty stages keep filling behind it.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert: pipelined 8-bit rgb to hsl converter
// Two restoring dividers run side by side for hue and saturation.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert import rhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_hue,
   output logic [15:0] rsp_saturation,
   output logic [8:0]  rsp_light_sum
);

   localparam int LAST = DIV_STEPS + 1;

   pipe_type    pipe_ff [0:DIV_STEPS];
   pipe_type    pipe_in [0:DIV_STEPS];
   logic        valid_ff [0:LAST];
   logic        adv [0:LAST];
   lane_type    hue_step [0:DIV_STEPS-1];
   lane_type    sat_step [0:DIV_STEPS-1];
   logic [14:0] hue_ff;
   logic [14:0] hue_in;
   logic [15:0] sat_ff;
   logic [15:0] sat_in;
   logic [8:0]  light_ff;
   logic [8:0]  light_in;

   // a stage may load when it is empty or its contents move on
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i + 1];
      end
   end

   // setup stage
   rhc_prep u_prep (
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .prep  (pipe_in[0])
   );

   // divide stages
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      rhc_div_step u_hue_step (
         .lane_in  (pipe_ff[k].hue_lane),
         .lane_out (hue_step[k])
      );
      rhc_div_step u_sat_step (
         .lane_in  (pipe_ff[k].sat_lane),
         .lane_out (sat_step[k])
      );
      always_comb begin
         pipe_in[k + 1]          = pipe_ff[k];
         pipe_in[k + 1].hue_lane = hue_step[k];
         pipe_in[k + 1].sat_lane = sat_step[k];
      end
   end

   // output assembly
   rhc_finish u_finish (
      .done       (pipe_ff[DIV_STEPS]),
      .hue        (hue_in),
      .saturation (sat_in),
      .light_sum  (light_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (adv[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i <= LAST; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i - 1];
         end
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
         if (adv[i]) pipe_ff[i] <= pipe_in[i];
      end
      if (adv[LAST]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
      end
   end

   assign req_stall      = !adv[0];
   assign rsp_valid      = valid_ff[LAST];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_light_sum  = light_ff;

endmodule

// File: rtl/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep: channel compare and divider setup
// Finds max, min, sector and hue difference, and forms both dividends.
// ----------------------------------------------------------------------------
module rhc_prep import rhc_pkg::*; (
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output pipe_type   prep
);

   logic       blue_max;
   logic       green_max;
   logic [7:0] mx;
   logic [7:0] mn;
   logic [8:0] diff;
   logic [8:0] diff_abs;
   logic [7:0] chroma;
   logic [8:0] sum;
   logic [8:0] den_hi;
   logic [7:0] denom;
   logic [19:0] hue_num;
   logic [23:0] sat_num;

   always_comb begin
      // max channel select, ties resolved toward red then green
      blue_max  = (blue > red) && (blue > green);
      green_max = !blue_max && (green > red);
      prep.sector = SECT_RED;
      mx   = red;
      diff = {1'b0, green} - {1'b0, blue};
      if (blue_max) begin
         prep.sector = SECT_BLUE;
         mx   = blue;
         diff = {1'b0, red} - {1'b0, green};
      end else if (green_max) begin
         prep.sector = SECT_GREEN;
         mx   = green;
         diff = {1'b0, blue} - {1'b0, red};
      end

      // min channel
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      chroma   = mx - mn;
      sum      = {1'b0, mx} + {1'b0, mn};
      prep.neg = diff[8];
      diff_abs = diff[8] ? (9'd0 - diff) : diff;

      // hue dividend: |diff| * 3840 = |diff| * 4096 - |diff| * 256
      hue_num = {diff_abs[7:0], 12'd0} - {4'd0, diff_abs[7:0], 8'd0};
      // saturation dividend: c * 65535
      sat_num = {chroma, 16'd0} - {16'd0, chroma};

      // saturation divisor 255 - |sum - 255|
      den_hi = LIGHT_FULL - sum;
      denom  = (sum <= CHAN_TOP) ? sum[7:0] : den_hi[7:0];

      prep.grey      = (chroma == 8'd0);
      prep.sat_zero  = (sum == 9'd0) || (sum == LIGHT_FULL);
      prep.light_sum = sum;

      // quotients fit 16 bits, so the top dividend bits seed the remainder
      prep.hue_lane.rem     = {4'd0, hue_num[19:16]};
      prep.hue_lane.work    = hue_num[15:0];
      prep.hue_lane.divisor = chroma;
      prep.sat_lane.rem     = sat_num[23:16];
      prep.sat_lane.work    = sat_num[15:0];
      prep.sat_lane.divisor = denom;
   end

endmodule

// File: rtl/rhc_div_step.sv
// ----------------------------------------------------------------------------
// rhc_div_step: one restoring division step
// Shifts one dividend bit into the remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
module rhc_div_step import rhc_pkg::*; (
   input  lane_type lane_in,
   output lane_type lane_out
);

   logic [8:0] trial;
   logic [8:0] trial_sub;
   logic       fits;

   always_comb begin
      // compare shifted remainder against divisor
      trial     = {lane_in.rem, lane_in.work[15]};
      trial_sub = trial - {1'b0, lane_in.divisor};
      fits      = (trial >= {1'b0, lane_in.divisor});

      lane_out.divisor = lane_in.divisor;
      lane_out.rem     = fits ? trial_sub[7:0] : trial[7:0];
      lane_out.work    = {lane_in.work[14:0], fits};
   end

endmodule

// File: rtl/rhc_finish.sv
// ----------------------------------------------------------------------------
// rhc_finish: hue and saturation assembly
// Applies floor rounding for negative hue, sector offset and wrap.
// ----------------------------------------------------------------------------
module rhc_finish import rhc_pkg::*; (
   input  pipe_type    done,
   output logic [14:0] hue,
   output logic [15:0] saturation,
   output logic [8:0]  light_sum
);

   logic [12:0] quo;
   logic [12:0] quo_up;
   logic [14:0] base;
   logic [14:0] neg_base;

   always_comb begin
      // hue quotient is at most 3840; round up magnitude for negative floor
      quo    = done.hue_lane.work[12:0];
      quo_up = quo + {12'd0, (done.hue_lane.rem != 8'd0)};

      // sector offset
      case (done.sector)
         SECT_GREEN: base = HUE_GREEN_BASE;
         SECT_BLUE:  base = HUE_BLUE_BASE;
         default:    base = 15'd0;
      endcase
      // negative red hue wraps around the full circle
      neg_base = (done.sector == SECT_RED) ? HUE_FULL : base;

      if (done.grey) begin
         hue = 15'd0;
      end else if (done.neg) begin
         hue = neg_base - {2'd0, quo_up};
      end else begin
         hue = base + {2'd0, quo};
      end

      saturation = done.sat_zero ? 16'd0 : done.sat_lane.work;
      light_sum  = done.light_sum;
   end

endmodule

// File: rtl/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker: port-level checks for the rgb to hsl converter
// Watches the result channel for range, holding and reset behavior.
// ----------------------------------------------------------------------------
module rhc_checker import rhc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_hue,
   input logic [15:0] rsp_saturation,
   input logic [8:0]  rsp_light_sum
);

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_light_sum))
      else $error("stalled result changed");

   // hue stays below a full circle
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_FULL)
      else $error("hue out of range");

   // lightness sum bounded by two full channels
   a_light_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_light_sum <= LIGHT_FULL)
      else $error("light sum out of range");

   // black and white have no saturation
   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_light_sum == 9'd0 || rsp_light_sum == LIGHT_FULL)
         |-> rsp_saturation == 16'd0)
      else $error("saturation nonzero at black or white");

endmodule

bind rgb_to_hsl_convert rhc_checker u_rhc_checker (.*);

// File: tb/sv/rgb_hsl_checker.sv
// ----------------------------------------------------------------------------
// rgb_hsl_checker: result predictor and scoreboard for rgb_to_hsl_convert
// Watches both channels, works out the expected hue, saturation and lightness
// sum of every accepted pixel and compares each result transfer in order.
// ----------------------------------------------------------------------------
module rgb_hsl_checker import rhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [14:0] rsp_hue,
   input  logic [15:0] rsp_saturation,
   input  logic [8:0]  rsp_light_sum,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          grey_count,
   output int          wrap_count,
   output int          bw_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAT_SCALE = 65535;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [8:0]  light_sum;
   } hsl_type;

   hsl_type hsl_q[$];

   // hue, saturation and max+min of one pixel
   function automatic hsl_type convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      int         ri, gi, bi, top, bottom, chroma, sum, diff, base, num, quot, hue, den;
      sector_type sect;
      hsl_type    res;
      ri = r;
      gi = g;
      bi = b;
      // blue wins only when strictly greatest, green only over red
      if (bi > ri && bi > gi) begin
         sect = SECT_BLUE;
         top  = bi;
         diff = ri - gi;
      end else if (gi > ri) begin
         sect = SECT_GREEN;
         top  = gi;
         diff = bi - ri;
      end else begin
         sect = SECT_RED;
         top  = ri;
         diff = gi - bi;
      end
      bottom = ri;
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      chroma = top - bottom;
      sum    = top + bottom;

      case (sect)
         SECT_GREEN: base = 2 * int'(HUE_SECTOR);
         SECT_BLUE:  base = 4 * int'(HUE_SECTOR);
         default:    base = 0;
      endcase

      // hue with floor division, wrapped into range for the red sector
      hue = 0;
      if (chroma > 0) begin
         num = int'(HUE_SECTOR) * diff;
         if (num >= 0) quot = num / chroma;
         else quot = -((-num + chroma - 1) / chroma);
         hue = base + quot;
         if (hue < 0) hue = hue + int'(HUE_FULL);
      end

      // saturation is zero for black and white
      res.saturation = '0;
      if (sum > 0 && sum < int'(LIGHT_FULL)) begin
         den = (sum <= int'(CHAN_TOP)) ? sum : int'(LIGHT_FULL) - sum;
         res.saturation = 16'((SAT_SCALE * chroma) / den);
      end
      res.hue       = 15'(hue);
      res.light_sum = 9'(sum);
      return res;
   endfunction

   // compare result transfers, then queue the prediction for a pixel transfer
   always @(posedge clock) begin
      hsl_type want;
      if (reset) begin
         fail_count = 0;
         pending    = 0;
         checked    = 0;
         grey_count = 0;
         wrap_count = 0;
         bw_count   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hsl_q.size() == 0) begin
               $error("result transfer with nothing expected: hue %0d sat %0d sum %0d",
                      rsp_hue, rsp_saturation, rsp_light_sum);
               fail_count++;
            end else begin
               want = hsl_q.pop_front();
               checked++;
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
                  fail_count++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d", want.saturation,
                         rsp_saturation);
                  fail_count++;
               end
               if (rsp_light_sum !== want.light_sum) begin
                  $error("light_sum: expected %0d, got %0d", want.light_sum,
                         rsp_light_sum);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = convert_pixel(req_red, req_green, req_blue);
            hsl_q.push_back(want);
            if (req_red == req_green && req_green == req_blue) grey_count++;
            if (want.light_sum == 9'd0 || want.light_sum == LIGHT_FULL) bw_count++;
            // red sector with green below blue wraps around 360 degrees
            if (req_red >= req_green && !(req_blue > req_red) && req_green < req_blue)
               wrap_count++;
         end
         pending = hsl_q.size();
      end
   end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for rgb_to_hsl_convert
// Drives corner pixels then mixed random pixels under random idling on both
// channels, one long result hold-off and one full drain; the checker scores.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 1630;
   localparam int IDLE_LIMIT    = 2000;
   localparam int LONG_HOLD     = 90;
   localparam int HOLD_AT       = 400;
   localparam int DRAIN_AT      = 900;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_hue;
   logic [15:0] rsp_saturation;
   logic [8:0]  rsp_light_sum;

   int fail_count, pending, checked, grey_count, wrap_count, bw_count;
   int idle_cycles = 0;
   bit tx_gappy = 1'b0;
   bit hold_wanted = 1'b0;
   bit hold_taken = 1'b0;

   always #5 clock = ~clock;

   rgb_to_hsl_convert uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_light_sum  (rsp_light_sum)
   );

   rgb_hsl_checker u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_light_sum  (rsp_light_sum),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked),
      .grey_count     (grey_count),
      .wrap_count     (wrap_count),
      .bw_count       (bw_count)
   );

   // offer one pixel after a random gap and wait for its transfer
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      gap = tx_gappy ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random pixel drawn from a mix of shapes
   task automatic random_pixel(output logic [7:0] r, output logic [7:0] g,
                               output logic [7:0] b);
      int          shape;
      logic [7:0]  level;
      logic [7:0]  ends [4];
      ends  = '{8'd0, 8'd1, 8'd254, 8'd255};
      shape = $urandom_range(0, 9);
      level = 8'($urandom);
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case (shape)
         // nearly grey, small chroma
         5, 6: begin
            r = level;
            g = level ^ 8'($urandom_range(0, 3));
            b = level ^ 8'($urandom_range(0, 3));
         end
         // extreme channel values
         7: begin
            r = ends[$urandom_range(0, 3)];
            g = ends[$urandom_range(0, 3)];
            b = ends[$urandom_range(0, 3)];
         end
         // two channels tied
         8: begin
            case ($urandom_range(0, 2))
               0: g = r;
               1: b = g;
               default: b = r;
            endcase
         end
         // near black or near white
         9: begin
            if ($urandom_range(0, 1)) begin
               r = 8'($urandom_range(0, 3));
               g = 8'($urandom_range(0, 3));
               b = 8'($urandom_range(0, 3));
            end else begin
               r = 8'($urandom_range(252, 255));
               g = 8'($urandom_range(252, 255));
               b = 8'($urandom_range(252, 255));
            end
         end
         default: ;
      endcase
   endtask

   // receiver: random stall per result, calm stretches, one long hold-off
   initial begin
      int  budget;
      int  moved;
      bit  rx_gappy;
      budget   = 0;
      moved    = 0;
      rx_gappy = 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            moved++;
            if (moved % 40 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
            budget = rx_gappy ? $urandom_range(0, 13) : 0;
         end
         if (hold_wanted && !hold_taken) begin
            budget     = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (budget > 0) begin
            budget--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("rgb_to_hsl_convert: mismatch");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [7:0] r, g, b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner pixels: black, white, grey, primaries, ties, wrap, small chroma
      tx_gappy = 1'b1;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd10);
      send_pixel(8'd10,  8'd0,   8'd255);
      send_pixel(8'd0,   8'd255, 8'd10);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd128, 8'd0,   8'd0);
      send_pixel(8'd128, 8'd127, 8'd127);
      send_pixel(8'd128, 8'd128, 8'd127);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd1,   8'd255, 8'd254);
      send_pixel(8'd127, 8'd127, 8'd128);
      send_pixel(8'd64,  8'd192, 8'd192);
      send_pixel(8'd170, 8'd85,  8'd85);

      // random pixels with burst and gappy stretches
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % 50 == 0) tx_gappy = ($urandom_range(0, 2) != 0);
         // hold the result side while pixels keep coming back to back
         if (i >= HOLD_AT && i < HOLD_AT + 100) tx_gappy = 1'b0;
         if (i == HOLD_AT) hold_wanted = 1'b1;
         if (i == DRAIN_AT) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(posedge clock);
         end
         random_pixel(r, g, b);
         send_pixel(r, g, b);
      end
      req_valid <= 1'b0;

      // drain and let the pipeline settle
      wait (pending == 0);
      repeat (24) @(posedge clock);

      $display("converted %0d pixels: %0d grey, %0d black or white, %0d red-sector wraps",
               checked, grey_count, bw_count, wrap_count);
      $display("both channels idled at random, with one long result hold-off and one drain");
      if (fail_count == 0) $display("rgb_to_hsl_convert: match");
      else $display("rgb_to_hsl_convert: mismatch");
      $finish;
   end

endmodule

// File: filelist.f
rtl/rhc_pkg.sv
rtl/rhc_prep.sv
rtl/rhc_div_step.sv
rtl/rhc_finish.sv
rtl/rgb_to_hsl_convert.sv
rtl/rhc_checker.sv
tb/sv/rgb_hsl_checker.sv
tb/sv/tb.sv
